// ===== sv/abt_pkg.sv =====
package abt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int FUNC_W = 3;
  localparam int ADDR_W = 8;
  localparam int TIME_W = 32;
  localparam int OFF_W  = 8;
  localparam int OCC_W  = 5;
  localparam int OCC_MAX = 31;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [FUNC_W-1:0] FN_CHECK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TRIGGER = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SWEEP   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BAN_DURATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFENCE_LIM  = 1'b1;

  localparam logic [TIME_W-1:0] BAN_DURATION_RST = 32'd60000;
  localparam logic [OFF_W-1:0]  OFFENCE_LIM_RST  = 8'd3;
  localparam logic [OFF_W-1:0]  OFF_SAT          = 8'hFF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] added;
    logic [TIME_W-1:0] expires;
    logic [OFF_W-1:0]  off;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  function automatic logic [OCC_W-1:0] occ_sat(input logic [CNT_W-1:0] c);
    logic [OCC_W-1:0] r;
    if (32'(c) > 32'(OCC_MAX)) begin
      r = OCC_W'(OCC_MAX);
    end else begin
      r = OCC_W'(c);
    end
    return r;
  endfunction

endpackage

// ===== sv/address_blacklist_table_core.sv =====
// After an input transfer the controller scans the table one entry per cycle, then passes
// through the drain and commit states; out_tvalid is set by the commit.
// A new input transfer is taken only in the idle state, so the next item waits until the
// previous one is committed; the single-port scan of the entry table sets the pace.
// Reset: synchronous, active low; clears the table, the occupied count and the output,
// and restores ban_duration_ms to 60000 and offence_limit to 3.
module address_blacklist_table_core import abt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata, from bit 0 up: func[2:0], addr[7:0], now_ms[31:0], five zero bits.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata, from bit 0 up: banned, occupied[4:0], two zero bits.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Register 0 is ban_duration_ms, register 1 is offence_limit (low 8 bits of data).
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // The controller walks the sixteen entries one per cycle, reading the entry memory
  // through its registered port. The datapath tracks the first matching slot, the
  // first free slot and the oldest entry added before now while the scan runs, and
  // in a sweep clears expired entries in place. In the commit cycle it applies at most one
  // memory write plus valid-bit updates and loads the output register. A finished
  // result waits in that register while the next input transfer is taken; commit
  // only stalls if the previous result has still not been transferred.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration writes are taken at any time outside reset.
  assign cfg_ready = rst_n;

  abt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  abt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sv/abt_ctrl.sv =====
module abt_ctrl import abt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  assign in_tready = rst_n && (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd.load   = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.rd_idx = idx_r;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // The last entry read is evaluated in this cycle.
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== sv/abt_datapath.sv =====
module abt_datapath import abt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Item registers.
  logic [FUNC_W-1:0] func_r;
  logic [ADDR_W-1:0] addr_r;
  logic [TIME_W-1:0] now_r;

  // Configuration.
  logic [TIME_W-1:0] dur_r;
  logic [OFF_W-1:0]  lim_r;

  // Entry storage; a slot whose valid bit is low counts as free, whatever its memory holds.
  entry_t           mem [ENTRIES];
  entry_t           rd_data_r;
  logic             rd_pend_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Scan trackers.
  logic             match_found_r, match_expd_r;
  logic [IDX_W-1:0] match_idx_r;
  entry_t           match_ent_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             old_found_r;
  logic [IDX_W-1:0] old_idx_r;
  logic [TIME_W-1:0] old_time_r;

  logic out_tvalid_r, out_banned_r;
  logic [OCC_W-1:0] out_occ_r;

  // Scan evaluation.
  logic ev_valid, ev_expd, is_match, is_free, is_old, sweep_clr;

  assign ev_valid  = valid_r[rd_idx_r];
  assign ev_expd   = (rd_data_r.expires != '0) && (now_r > rd_data_r.expires);
  assign is_match  = rd_pend_r && ev_valid && !match_found_r &&
                     (addr_r != '0) && (rd_data_r.addr == addr_r);
  assign is_free   = rd_pend_r && !ev_valid && !free_found_r;
  assign is_old    = rd_pend_r && ev_valid && (rd_data_r.added < now_r) &&
                     (!old_found_r || (rd_data_r.added < old_time_r));
  assign sweep_clr = rd_pend_r && (func_r == FN_SWEEP) && ev_valid && ev_expd;

  // Commit decision.
  logic             wr_en, set_v, clr_v, inc, dec, banned;
  logic [IDX_W-1:0] wr_idx, clr_idx, pick_idx;
  entry_t           wr_data, ban_ent;
  logic             m_banned, m_live;
  logic [OFF_W-1:0] off_new;
  logic [TIME_W-1:0] exp_at;

  assign exp_at   = now_r + dur_r;
  assign ban_ent  = '{addr: addr_r, added: now_r, expires: exp_at, off: lim_r};
  assign m_banned = (match_ent_r.expires != '0) || (match_ent_r.off >= lim_r);
  assign m_live   = match_found_r && !match_expd_r;
  assign off_new  = (match_ent_r.off == OFF_SAT) ? OFF_SAT : match_ent_r.off + 1'b1;
  assign pick_idx = (free_found_r && (free_idx_r < match_idx_r)) ? free_idx_r : match_idx_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = match_idx_r;
    wr_data = ban_ent;
    set_v   = 1'b0;
    clr_v   = 1'b0;
    clr_idx = match_idx_r;
    inc     = 1'b0;
    dec     = 1'b0;
    banned  = 1'b0;
    if (cmd.commit && (addr_r != '0)) begin
      case (func_r)
        FN_CHECK: begin
          if (match_found_r) begin
            if (match_expd_r) begin
              clr_v = 1'b1;
              dec   = 1'b1;
            end else begin
              banned = m_banned;
            end
          end
        end
        FN_ADD: begin
          if (m_live) begin
            if (!m_banned) begin
              wr_en = 1'b1;
            end
          end else if (match_found_r) begin
            // Expired match is freed first, then the lowest free slot is used.
            clr_v  = 1'b1;
            dec    = 1'b1;
            wr_en  = 1'b1;
            wr_idx = pick_idx;
            set_v  = 1'b1;
            inc    = 1'b1;
          end else if (free_found_r) begin
            wr_en  = 1'b1;
            wr_idx = free_idx_r;
            set_v  = 1'b1;
            inc    = 1'b1;
          end else if (old_found_r) begin
            wr_en  = 1'b1;
            wr_idx = old_idx_r;
          end
        end
        FN_REMOVE: begin
          if (match_found_r) begin
            clr_v = 1'b1;
            dec   = 1'b1;
          end
        end
        FN_TRIGGER: begin
          if (match_found_r) begin
            wr_en   = 1'b1;
            wr_data = '{addr: match_ent_r.addr, added: match_ent_r.added,
                        expires: (off_new >= lim_r) ? exp_at : match_ent_r.expires,
                        off: off_new};
          end else if (free_found_r) begin
            wr_en   = 1'b1;
            wr_idx  = free_idx_r;
            wr_data = '{addr: addr_r, added: now_r,
                        expires: (OFF_W'(1) >= lim_r) ? exp_at : '0,
                        off: OFF_W'(1)};
            set_v   = 1'b1;
            inc     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (sweep_clr) begin
      valid_nxt[rd_idx_r] = 1'b0;
    end
    if (clr_v) begin
      valid_nxt[clr_idx] = 1'b0;
    end
    if (set_v) begin
      valid_nxt[wr_idx] = 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(inc) - CNT_W'(dec) - CNT_W'(sweep_clr);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r     <= 1'b0;
      valid_r       <= '0;
      cnt_r         <= '0;
      dur_r         <= BAN_DURATION_RST;
      lim_r         <= OFFENCE_LIM_RST;
      out_tvalid_r  <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      old_found_r   <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
      valid_r   <= valid_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_BAN_DURATION) begin
          dur_r <= cfg_data;
        end else begin
          lim_r <= cfg_data[OFF_W-1:0];
        end
      end
      if (cmd.commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cmd.load) begin
        match_found_r <= 1'b0;
        free_found_r  <= 1'b0;
        old_found_r   <= 1'b0;
      end else begin
        if (is_match) begin
          match_found_r <= 1'b1;
        end
        if (is_free) begin
          free_found_r <= 1'b1;
        end
        if (is_old) begin
          old_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cmd.rd_idx;
    if (cmd.load) begin
      func_r <= in_tdata[FUNC_W-1:0];
      addr_r <= in_tdata[FUNC_W+ADDR_W-1:FUNC_W];
      now_r  <= in_tdata[FUNC_W+ADDR_W+TIME_W-1:FUNC_W+ADDR_W];
    end
    if (is_match) begin
      match_idx_r  <= rd_idx_r;
      match_ent_r  <= rd_data_r;
      match_expd_r <= ev_expd;
    end
    if (is_free) begin
      free_idx_r <= rd_idx_r;
    end
    if (is_old) begin
      old_idx_r  <= rd_idx_r;
      old_time_r <= rd_data_r.added;
    end
    if (cmd.commit) begin
      out_banned_r <= banned;
      out_occ_r    <= occ_sat(cnt_nxt);
    end
  end

  assign sts.out_free = !out_tvalid_r || out_tready;
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = {(OUT_TDATA_W-OCC_W-1)'(0), out_occ_r, out_banned_r};

endmodule

// ===== sv/abt_checker.sv =====
module abt_checker import abt_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // One item at a time: an accepted item closes the input until it is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again right after a transfer");

  // The result takes the full scan, so it cannot appear on the next cycle.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // The occupied count never exceeds the table size and the pad bits stay zero.
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:6] == 2'b00) &&
                   (32'(out_tdata[5:1]) <= 32'(ENTRIES)))
    else $error("occupied count out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind address_blacklist_table_core abt_checker u_abt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
